// ----- design/sha1s_pkg.sv -----
package sha1s_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned HashWords  = 5;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds     = 80;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam word_t IV [HashWords] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam word_t PAD_WORD = 32'h80000000;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ----- design/sha1s_if.sv -----
interface sha1s_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        end_of_message;

	modport source (output valid, data_word, byte_count, end_of_message, input ready);
	modport sink   (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha1s_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- design/sha1_stream_hasher.sv -----
// Channel  Dir  Payload                                  Transaction
// msg      in   data_word, byte_count, end_of_message    one message word (final may be short)
// digest   out  digest_word, word_index, last_word       one digest word, five per message
//
// Each message word is taken while idle; every 16th word starts a compression that runs
// the 80 rounds through the single round adder, then folds into the chained hash.
// The final word is followed by pad words, one or two compressions and five digest
// transactions.
// arst_n clears the sequencer and loads the standard initial hash values.
// msg.ready is low while compressing, padding or draining the digest; digest stalls hold.
module sha1_stream_hasher
	import sha1s_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sha1s_msg_if.sink             msg,
	sha1s_digest_if.source        digest
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUND = 3'd1;
	localparam logic [2:0] S_FOLD  = 3'd2;
	localparam logic [2:0] S_PAD   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]  state_q;
	word_t       h_q [HashWords];     // chained hash
	word_t       w_q [BlockWords];    // message schedule window, w_q[0] is oldest
	word_t       a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  t_q;                 // round counter
	logic [3:0]  wpos_q;              // words held in the current block
	logic [60:0] bytes_q;             // message length in bytes, wraps
	logic        padding_q;           // final word seen, padding in progress
	logic        pad80_q;             // lone pad-marker word still owed
	logic        len_hi_q;            // high length word pushed, low word next
	logic        done_q;              // last block of the message is loaded
	logic [2:0]  oidx_q;

	logic        msg_acc, dig_acc;
	logic [2:0]  cnt;
	word_t       keep_mask, pad_bits;
	logic        push_en;
	word_t       push_word;
	word_t       wt, f_val, k_val, tmp;

	assign msg.ready    = (state_q == S_IDLE);
	assign msg_acc      = msg.valid && msg.ready;
	assign digest.valid = (state_q == S_OUT);
	assign dig_acc      = digest.valid && digest.ready;

	assign digest.digest_word = h_q[oidx_q];
	assign digest.word_index  = oidx_q;
	assign digest.last_word   = (oidx_q == 3'(HashWords - 1));

	// Clamp the byte count; anything above four means a full word.
	assign cnt = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

	always_comb begin
		case (cnt)
			3'd0:    begin keep_mask = 32'h00000000; pad_bits = 32'h80000000; end
			3'd1:    begin keep_mask = 32'hFF000000; pad_bits = 32'h00800000; end
			3'd2:    begin keep_mask = 32'hFFFF0000; pad_bits = 32'h00008000; end
			3'd3:    begin keep_mask = 32'hFFFFFF00; pad_bits = 32'h00000080; end
			default: begin keep_mask = 32'hFFFFFFFF; pad_bits = 32'h00000000; end
		endcase
	end

	// Select the word entering the block buffer this cycle.
	always_comb begin
		push_en   = 1'b0;
		push_word = '0;
		if (msg_acc) begin
			push_en   = 1'b1;
			push_word = msg.end_of_message ? ((msg.data_word & keep_mask) | pad_bits)
			                               : msg.data_word;
		end else if (state_q == S_PAD) begin
			push_en = 1'b1;
			if (pad80_q)
				push_word = PAD_WORD;
			else if (len_hi_q)
				push_word = {bytes_q[28:0], 3'b000};
			else if (wpos_q == 4'd14)
				push_word = bytes_q[60:29];
			else
				push_word = '0;
		end
	end

	// One SHA-1 round: schedule word, round function and the five-input add.
	always_comb begin
		wt = (t_q < 7'd16) ? w_q[0] : rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		if (t_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (t_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (t_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
		tmp = rotl(a_q, 5) + f_val + e_q + k_val + wt;
	end

	// Schedule window and round registers carry no reset.
	always_ff @(posedge clk) begin
		if (push_en || state_q == S_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[BlockWords - 1] <= (state_q == S_ROUND) ? wt : push_word;
		end
		if (push_en && wpos_q == 4'd15) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == S_ROUND) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= rotl(b_q, 30);
			b_q <= a_q;
			a_q <= tmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			for (int i = 0; i < HashWords; i++)
				h_q[i] <= IV[i];
			t_q       <= '0;
			wpos_q    <= '0;
			bytes_q   <= '0;
			padding_q <= 1'b0;
			pad80_q   <= 1'b0;
			len_hi_q  <= 1'b0;
			done_q    <= 1'b0;
			oidx_q    <= '0;
		end else begin
			// Track length and padding bookkeeping on each accepted word.
			if (msg_acc) begin
				if (msg.end_of_message) begin
					bytes_q   <= bytes_q + 61'(cnt);
					padding_q <= 1'b1;
					pad80_q   <= (cnt == 3'd4);
					len_hi_q  <= 1'b0;
					done_q    <= 1'b0;
				end else begin
					bytes_q <= bytes_q + 61'd4;
				end
			end
			if (state_q == S_PAD) begin
				if (pad80_q)
					pad80_q <= 1'b0;
				else if (len_hi_q) begin
					len_hi_q <= 1'b0;
					done_q   <= 1'b1;
				end else if (wpos_q == 4'd14)
					len_hi_q <= 1'b1;
			end
			if (push_en)
				wpos_q <= wpos_q + 4'd1;

			unique case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						if (wpos_q == 4'd15) begin
							state_q <= S_ROUND;
							t_q     <= '0;
						end else if (msg.end_of_message)
							state_q <= S_PAD;
					end
				end
				S_PAD: begin
					if (wpos_q == 4'd15) begin
						state_q <= S_ROUND;
						t_q     <= '0;
					end
				end
				S_ROUND: begin
					t_q <= t_q + 7'd1;
					if (t_q == 7'(Rounds - 1))
						state_q <= S_FOLD;
				end
				S_FOLD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (!padding_q)
						state_q <= S_IDLE;
					else if (done_q)
						state_q <= S_OUT;
					else
						state_q <= S_PAD;
				end
				S_OUT: begin
					if (dig_acc) begin
						if (oidx_q == 3'(HashWords - 1)) begin
							// Restart the chain for the next message.
							for (int i = 0; i < HashWords; i++)
								h_q[i] <= IV[i];
							bytes_q   <= '0;
							wpos_q    <= '0;
							padding_q <= 1'b0;
							done_q    <= 1'b0;
							oidx_q    <= '0;
							state_q   <= S_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input side never opens while a digest is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("msg ready while digest valid");

	// A compression always starts on an empty block position.
	a_round_wpos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (wpos_q == 4'd0 && t_q < 7'(Rounds)))
		else $error("round state with stray block position");

	// After the fifth digest word the chain is back at the initial values.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && digest.last_word) |=>
			(h_q[0] == IV[0] && h_q[4] == IV[4] && bytes_q == '0 && state_q == S_IDLE))
		else $error("hash not restarted after digest");

	// Digest output only after the length words have gone in.
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest.valid) |-> ($past(state_q) == S_FOLD && done_q))
		else $error("digest offered before padding finished");

endmodule
